// File: hw/rtl/stm_pkg.sv
`default_nettype none

package stm_pkg;

  localparam int COLS = 12;
  localparam int PIXELS = 96;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_RENDER = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 6;
  localparam logic [CFG_AW-1:0] REG_TEXT_ROW       = 3'd0;
  localparam logic [CFG_AW-1:0] REG_WINDOW_LEFT    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_WINDOW_RIGHT   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_CHAR_GAP       = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MESSAGE_LENGTH = 3'd4;

  typedef struct packed {
    logic [1:0]        command;
    logic [4:0]        char_index;
    logic [5:0]        char_code;
    logic [1:0]        word_index;
    logic [31:0]       word_value;
    logic signed [7:0] scroll_step;
  } in_item_t;

  typedef struct packed {
    logic [31:0] frame_word0;
    logic [31:0] frame_word1;
    logic [31:0] frame_word2;
  } out_item_t;

  typedef struct packed {
    logic [2:0] text_row;
    logic [3:0] window_left;
    logic [3:0] window_right;
    logic [3:0] char_gap;
    logic [5:0] message_length;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_WRITE,
    OP_RENDER,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t      op;
    in_item_t item;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_FETCH,
    ST_GLYPH,
    ST_FINAL,
    ST_DONE
  } st_t;

  function automatic logic [11:0] font_glyph(input logic [5:0] code);
    logic [11:0] g;
    case (code)
      6'd0:  g = 12'h57D;
      6'd1:  g = 12'h9EF;
      6'd2:  g = 12'h723;
      6'd3:  g = 12'hD6E;
      6'd4:  g = 12'h7E3;
      6'd5:  g = 12'h73C;
      6'd6:  g = 12'h72F;
      6'd7:  g = 12'hB7D;
      6'd8:  g = 12'hE97;
      6'd9:  g = 12'hE94;
      6'd10: g = 12'hBAD;
      6'd11: g = 12'h927;
      6'd12: g = 12'hBED;
      6'd13: g = 12'h1ED;
      6'd14: g = 12'hF6F;
      6'd15: g = 12'hF7C;
      6'd16: g = 12'h771;
      6'd17: g = 12'hF75;
      6'd18: g = 12'hF0F;
      6'd19: g = 12'hE92;
      6'd20: g = 12'hB6F;
      6'd21: g = 12'hB6A;
      6'd22: g = 12'h17F;
      6'd23: g = 12'hA95;
      6'd24: g = 12'hB52;
      6'd25: g = 12'hEF7;
      6'd26: g = 12'h56A;
      6'd27: g = 12'h597;
      6'd28: g = 12'hC67;
      6'd29: g = 12'hE4F;
      6'd30: g = 12'hB79;
      6'd31: g = 12'hF0F;
      6'd32: g = 12'hF3F;
      6'd33: g = 12'hE52;
      6'd34: g = 12'hFEF;
      6'd35: g = 12'hFCF;
      default: g = 12'h000;
    endcase
    return g;
  endfunction

  // Columns lo..hi, clipped to the window lft..rgt.
  function automatic logic [11:0] col_mask(input logic signed [11:0] lo,
                                           input logic signed [11:0] hi,
                                           input logic signed [11:0] lft,
                                           input logic signed [11:0] rgt);
    logic [11:0] m;
    logic signed [11:0] cs;
    for (int c = 0; c < COLS; c++) begin
      cs = 12'(c);
      m[c] = (cs >= lo) && (cs <= hi) && (cs >= lft) && (cs <= rgt);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/stm_front.sv
`default_nettype none

module stm_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire stm_pkg::in_item_t item,
  output logic                   full,
  output logic                   job_valid,
  output stm_pkg::job_t          job,
  input  wire logic              job_ready
);

  stm_pkg::job_t q_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push, do_pop;
  stm_pkg::job_t cls;

  always_comb begin
    cls.item = item;
    case (item.command)
      stm_pkg::CMD_LOAD:   cls.op = stm_pkg::OP_LOAD;
      stm_pkg::CMD_WRITE:  cls.op = stm_pkg::OP_WRITE;
      stm_pkg::CMD_RENDER: cls.op = stm_pkg::OP_RENDER;
      default:             cls.op = stm_pkg::OP_NONE;
    endcase
  end

  assign full      = (cnt_r == 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = job_valid && job_ready;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/stm_back.sv
`default_nettype none

module stm_back #(
  parameter int MAX_CHARS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               job_valid,
  input  wire stm_pkg::job_t      job,
  output logic                    job_ready,
  input  wire stm_pkg::cfg_t      cfg,
  output logic                    out_valid,
  output stm_pkg::out_item_t      out_item,
  input  wire logic               out_pop
);

  localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int KW = $clog2(MAX_CHARS + 1);

  logic [5:0]         msg_mem [MAX_CHARS];
  logic [5:0]         rd_r;

  stm_pkg::st_t       st_r, st_nxt;
  logic [95:0]        frame_r, frame_nxt;
  logic signed [11:0] col_r, col_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic signed [7:0]  step_r, step_nxt;
  logic               out_valid_r;
  stm_pkg::out_item_t out_r;

  logic signed [11:0] lft, rgt, gap, wid, col0;
  logic [KW-1:0]      n;
  logic signed [12:0] lim;
  logic               full_clr, last_k, take;
  logic               mem_we, word_we;
  logic [11:0]        clr, drw, glyph;
  logic [3:0]         gbits [stm_pkg::COLS];
  logic signed [11:0] d, cs;

  assign job_ready = (st_r == stm_pkg::ST_IDLE) && !out_valid_r;
  assign take      = job_ready && job_valid;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    lft = $signed({8'b0, cfg.window_left});
    rgt = (cfg.window_right > 4'd11) ? 12'sd11 : $signed({8'b0, cfg.window_right});
    gap = $signed({8'b0, cfg.char_gap});
    wid = gap + 12'sd3;
    n   = ({2'b0, cfg.message_length} > 8'(MAX_CHARS)) ? KW'(MAX_CHARS)
                                                       : KW'(cfg.message_length);
    lim = $signed(13'(n) * 13'(wid[4:0])) - $signed({9'b0, cfg.char_gap});
    col0 = rgt - 12'sd2 + 12'(step_r);
    full_clr = 13'(step_r) >= lim;
    last_k = (k_r + KW'(1)) == n;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      stm_pkg::ST_IDLE: begin
        if (take) begin
          st_nxt = (job.op == stm_pkg::OP_RENDER) ? stm_pkg::ST_START : stm_pkg::ST_DONE;
        end
      end
      stm_pkg::ST_START: begin
        if (full_clr) begin
          st_nxt = stm_pkg::ST_DONE;
        end else if (n == '0) begin
          st_nxt = stm_pkg::ST_FINAL;
        end else begin
          st_nxt = stm_pkg::ST_FETCH;
        end
      end
      stm_pkg::ST_FETCH: begin
        if (col_r > 12'sd11) begin
          st_nxt = last_k ? stm_pkg::ST_FINAL : stm_pkg::ST_FETCH;
        end else if (col_r < -12'sd2) begin
          st_nxt = stm_pkg::ST_FINAL;
        end else begin
          st_nxt = stm_pkg::ST_GLYPH;
        end
      end
      stm_pkg::ST_GLYPH: begin
        st_nxt = last_k ? stm_pkg::ST_FINAL : stm_pkg::ST_FETCH;
      end
      stm_pkg::ST_FINAL: st_nxt = stm_pkg::ST_DONE;
      stm_pkg::ST_DONE:  st_nxt = stm_pkg::ST_IDLE;
      default:           st_nxt = stm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    clr      = '0;
    drw      = '0;
    col_nxt  = col_r;
    k_nxt    = k_r;
    step_nxt = step_r;
    mem_we   = 1'b0;
    word_we  = 1'b0;
    case (st_r)
      stm_pkg::ST_IDLE: begin
        if (take) begin
          step_nxt = job.item.scroll_step;
          mem_we   = (job.op == stm_pkg::OP_LOAD) &&
                     ({2'b0, job.item.char_index} < 7'(MAX_CHARS));
          word_we  = (job.op == stm_pkg::OP_WRITE) && (job.item.word_index != 2'd3);
        end
      end
      stm_pkg::ST_START: begin
        k_nxt   = '0;
        col_nxt = col0;
        if (full_clr) begin
          clr = stm_pkg::col_mask(lft, rgt, lft, rgt);
        end else if (step_r < 8'sd0) begin
          clr = stm_pkg::col_mask(col0 + 12'sd3, rgt, lft, rgt);
        end
      end
      stm_pkg::ST_FETCH: begin
        if (col_r > 12'sd11) begin
          col_nxt = col_r - wid;
          k_nxt   = k_r + KW'(1);
        end
      end
      stm_pkg::ST_GLYPH: begin
        clr = stm_pkg::col_mask(col_r - gap, col_r - 12'sd1, lft, rgt);
        if (gap != 12'sd0 && (rgt - col_r) >= 12'sd2 && (rgt - col_r) < wid) begin
          clr = clr | stm_pkg::col_mask(col_r + 12'sd3, rgt, lft, rgt);
        end
        drw     = stm_pkg::col_mask(col_r, col_r + 12'sd2, lft, rgt);
        col_nxt = col_r - wid;
        k_nxt   = k_r + KW'(1);
      end
      stm_pkg::ST_FINAL: begin
        clr = stm_pkg::col_mask(lft, col_r - 12'sd1, lft, rgt);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    glyph = stm_pkg::font_glyph(rd_r);
    for (int c = 0; c < stm_pkg::COLS; c++) begin
      cs = 12'(c);
      d  = cs - col_r;
      case (d[1:0])
        2'd0:    gbits[c] = {glyph[9], glyph[6], glyph[3], glyph[0]};
        2'd1:    gbits[c] = {glyph[10], glyph[7], glyph[4], glyph[1]};
        default: gbits[c] = {glyph[11], glyph[8], glyph[5], glyph[2]};
      endcase
    end
  end

  always_comb begin
    int r, c, dr;
    frame_nxt = frame_r;
    for (int p = 0; p < stm_pkg::PIXELS; p++) begin
      r  = p / stm_pkg::COLS;
      c  = p % stm_pkg::COLS;
      dr = r - int'(cfg.text_row);
      if (dr >= 0 && dr < 4) begin
        if (clr[c]) begin
          frame_nxt[p] = 1'b0;
        end else if (drw[c]) begin
          frame_nxt[p] = gbits[c][dr[1:0]];
        end
      end
    end
    if (word_we) begin
      case (job.item.word_index)
        2'd0:    frame_nxt[95:64] = job.item.word_value;
        2'd1:    frame_nxt[63:32] = job.item.word_value;
        default: frame_nxt[31:0]  = job.item.word_value;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      msg_mem[AW'(job.item.char_index)] <= job.item.char_code;
    end
    rd_r <= msg_mem[k_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    col_r  <= col_nxt;
    k_r    <= k_nxt;
    step_r <= step_nxt;
    if (st_r == stm_pkg::ST_DONE) begin
      out_r <= '{frame_word0: frame_r[95:64], frame_word1: frame_r[63:32],
                 frame_word2: frame_r[31:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= stm_pkg::ST_IDLE;
      frame_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      frame_r <= frame_nxt;
      if (st_r == stm_pkg::ST_DONE) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/scrolling_text_marquee_renderer_unit.sv
`default_nettype none

// Scrolling text marquee renderer for a 12x8 one-bit LED frame. Each transaction
// loads a message character, overwrites a frame word, renders the message at a
// scroll step, or does nothing (unused command); every transaction returns the
// whole frame. A two-entry queue decodes incoming transactions ahead of the
// executor. Load, write and unused commands pass from idle straight to done in the
// executor. A render whose step puts the whole message past the window goes from
// start to done; any other render walks the one-read message memory one glyph at
// a time, skipping glyphs to the right of the frame, drawing each glyph in reach,
// stopping at a glyph past the left edge, and then clears the rest of the window.
// A new transaction is started only once the previous result has been popped.
module scrolling_text_marquee_renderer_unit #(
  parameter int MAX_CHARS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  input  wire stm_pkg::in_item_t             in_item,
  output logic                               in_full,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output stm_pkg::out_item_t                 out_item,
  input  wire logic                          cfg_we,
  input  wire logic [stm_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire logic [stm_pkg::CFG_DW-1:0]    cfg_wdata
);

  stm_pkg::cfg_t cfg_r, cfg_nxt;
  logic          job_valid, job_ready, out_valid;
  stm_pkg::job_t job;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        stm_pkg::REG_TEXT_ROW:       cfg_nxt.text_row       = cfg_wdata[2:0];
        stm_pkg::REG_WINDOW_LEFT:    cfg_nxt.window_left    = cfg_wdata[3:0];
        stm_pkg::REG_WINDOW_RIGHT:   cfg_nxt.window_right   = cfg_wdata[3:0];
        stm_pkg::REG_CHAR_GAP:       cfg_nxt.char_gap       = cfg_wdata[3:0];
        stm_pkg::REG_MESSAGE_LENGTH: cfg_nxt.message_length = cfg_wdata[5:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{text_row: 3'd0, window_left: 4'd0, window_right: 4'd11,
                 char_gap: 4'd1, message_length: 6'd0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  stm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .item      (in_item),
    .full      (in_full),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready)
  );

  stm_back #(
    .MAX_CHARS (MAX_CHARS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_pop   (out_pop)
  );

  assign out_empty = !out_valid;

endmodule

`default_nettype wire

// File: dv/scrolling_text_marquee_renderer_unit_tb.sv
`timescale 1ns / 1ps

module scrolling_text_marquee_renderer_unit_tb;

  class frame_scoreboard;
    logic [31:0] frame_q[3];
    logic [5:0]  codes_q[32];
    int unsigned text_row_q, left_q, right_q, gap_q, len_q;
    stm_pkg::out_item_t pending_frames[$];
    int          errors;

    function void reset_state();
      for (int i = 0; i < 3; i++) frame_q[i] = '0;
      for (int i = 0; i < 32; i++) codes_q[i] = '0;
      text_row_q = 0; left_q = 0; right_q = 11; gap_q = 1; len_q = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [stm_pkg::CFG_AW-1:0] idx, logic [stm_pkg::CFG_DW-1:0] v);
      case (idx)
        stm_pkg::REG_TEXT_ROW:       text_row_q = v[2:0];
        stm_pkg::REG_WINDOW_LEFT:    left_q = v[3:0];
        stm_pkg::REG_WINDOW_RIGHT:   right_q = v[3:0];
        stm_pkg::REG_CHAR_GAP:       gap_q = v[3:0];
        stm_pkg::REG_MESSAGE_LENGTH: len_q = v[5:0];
        default: ;
      endcase
    endfunction

    function void set_pixel(int r, int c, bit on);
      int p;
      if (r < 0 || c < 0 || c >= stm_pkg::COLS) return;
      p = r * stm_pkg::COLS + c;
      if (p >= stm_pkg::PIXELS) return;
      frame_q[2 - p / 32][p % 32] = on;
    endfunction

    function void blank_cols(int lo, int hi, int lft, int rgt);
      if (lo < lft) lo = lft;
      if (hi > rgt) hi = rgt;
      for (int c = lo; c <= hi; c++)
        for (int r = text_row_q; r < text_row_q + 4; r++) set_pixel(r, c, 0);
    endfunction

    function logic [11:0] glyph_bits(logic [5:0] code);
      logic [11:0] tbl[36];
      tbl = '{12'h57D, 12'h9EF, 12'h723, 12'hD6E, 12'h7E3, 12'h73C, 12'h72F,
              12'hB7D, 12'hE97, 12'hE94, 12'hBAD, 12'h927, 12'hBED, 12'h1ED,
              12'hF6F, 12'hF7C, 12'h771, 12'hF75, 12'hF0F, 12'hE92, 12'hB6F,
              12'hB6A, 12'h17F, 12'hA95, 12'hB52, 12'hEF7, 12'h56A, 12'h597,
              12'hC67, 12'hE4F, 12'hB79, 12'hF0F, 12'hF3F, 12'hE52, 12'hFEF,
              12'hFCF};
      return (code < 36) ? tbl[code] : 12'h000;
    endfunction

    function void render_step(int step);
      int lft, rgt, g, w, n, col;
      logic [11:0] gb;
      lft = left_q;
      rgt = (right_q > 11) ? 11 : right_q;
      g = gap_q;
      w = 3 + g;
      n = (len_q > 32) ? 32 : len_q;
      col = rgt - 2 + step;
      if (step >= n * w - g) begin
        blank_cols(lft, rgt, lft, rgt);
        return;
      end
      if (step < 0) blank_cols(col + 3, rgt, lft, rgt);
      for (int k = 0; k < n; k++) begin
        if (col > 11) begin
          col -= w;
          continue;
        end
        if (col < -2) break;
        if (g != 0 && rgt - col >= 2 && rgt - col < w) blank_cols(col + 3, rgt, lft, rgt);
        gb = glyph_bits(codes_q[k]);
        for (int dc = 0; dc < 3; dc++) begin
          if (col + dc < lft || col + dc > rgt) continue;
          for (int dr = 0; dr < 4; dr++)
            set_pixel(text_row_q + dr, col + dc, gb[dc + 3 * dr]);
        end
        if (g != 0 && col > lft) blank_cols((col - g < lft) ? lft : col - g, col - 1, lft, rgt);
        col -= w;
      end
      if (col > lft) blank_cols(lft, col - 1, lft, rgt);
    endfunction

    function void note_input(stm_pkg::in_item_t it);
      stm_pkg::out_item_t o;
      case (it.command)
        stm_pkg::CMD_LOAD:   codes_q[it.char_index] = it.char_code;
        stm_pkg::CMD_WRITE:  if (it.word_index < 3) frame_q[it.word_index] = it.word_value;
        stm_pkg::CMD_RENDER: render_step(int'(it.scroll_step));
        default: ;
      endcase
      o.frame_word0 = frame_q[0];
      o.frame_word1 = frame_q[1];
      o.frame_word2 = frame_q[2];
      pending_frames.push_back(o);
    endfunction

    function void check_result(stm_pkg::out_item_t got);
      stm_pkg::out_item_t want;
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending_frames.pop_front();
      if (got.frame_word0 !== want.frame_word0) begin
        $display("%0t: frame_word0 expected %h actual %h", $time, want.frame_word0,
                 got.frame_word0);
        errors++;
      end
      if (got.frame_word1 !== want.frame_word1) begin
        $display("%0t: frame_word1 expected %h actual %h", $time, want.frame_word1,
                 got.frame_word1);
        errors++;
      end
      if (got.frame_word2 !== want.frame_word2) begin
        $display("%0t: frame_word2 expected %h actual %h", $time, want.frame_word2,
                 got.frame_word2);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, in_push, in_full, out_empty, out_pop, cfg_we;
  stm_pkg::in_item_t in_item;
  stm_pkg::out_item_t out_item;
  logic [stm_pkg::CFG_AW-1:0] cfg_addr;
  logic [stm_pkg::CFG_DW-1:0] cfg_wdata;

  frame_scoreboard sb;
  int send_idle_pct, recv_stall_pct, hold_cycles;

  scrolling_text_marquee_renderer_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_item(in_item), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) sb.check_result(out_item);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_pop <= 0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_item(stm_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 0;
      @(posedge clk);
    end
    in_push <= 1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_push <= 0;
    @(posedge clk);
    while (sb.pending_frames.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [stm_pkg::CFG_AW-1:0] idx, logic [stm_pkg::CFG_DW-1:0] v);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  function automatic stm_pkg::in_item_t rand_item(int unsigned cmd);
    stm_pkg::in_item_t it;
    it.command = 2'(cmd);
    it.char_index = 5'($urandom);
    it.char_code = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(35));
    it.word_index = 2'($urandom);
    it.word_value = $urandom;
    it.scroll_step = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(132) - 12);
    return it;
  endfunction

  task automatic load_all();
    stm_pkg::in_item_t it;
    for (int i = 0; i < 32; i++) begin
      it = rand_item(stm_pkg::CMD_LOAD);
      it.char_index = 5'(i);
      push_item(it);
    end
  endtask

  task automatic random_config(int unsigned mode);
    int unsigned l, r;
    l = (mode == 0) ? 0 : $urandom_range(11);
    r = (mode == 0) ? 11 : ($urandom_range(4) == 0 ? $urandom_range(15) : $urandom_range(11));
    write_reg(stm_pkg::REG_TEXT_ROW, 6'((mode == 1) ? 7 : $urandom_range(4)));
    write_reg(stm_pkg::REG_WINDOW_LEFT, 6'((mode == 1) ? 15 : l));
    write_reg(stm_pkg::REG_WINDOW_RIGHT, 6'((mode == 1) ? 15 : r));
    write_reg(stm_pkg::REG_CHAR_GAP, 6'((mode == 1) ? 15 : $urandom_range(8)));
    write_reg(stm_pkg::REG_MESSAGE_LENGTH, 6'((mode == 1) ? 63 : $urandom_range(32)));
  endtask

  initial begin
    stm_pkg::in_item_t it;
    sb = new();
    sb.reset_state();
    rst_n = 0; in_push = 0; in_item = '0; out_pop = 0;
    cfg_we = 0; cfg_addr = '0; cfg_wdata = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    load_all();
    it = rand_item(stm_pkg::CMD_RENDER); it.scroll_step = 0; push_item(it);
    drain();
    write_reg(stm_pkg::REG_MESSAGE_LENGTH, 6'd4);
    for (int s = 0; s < 6; s++) begin
      it = rand_item(stm_pkg::CMD_RENDER);
      it.scroll_step = (s == 0) ? -8'sd12 : (s == 1) ? 8'sd120 : (s == 2) ? -8'sd128 :
                       (s == 3) ? 8'sd127 : (s == 4) ? -8'sd1 : 8'sd5;
      push_item(it);
    end
    it = rand_item(stm_pkg::CMD_WRITE); it.word_index = 0; it.word_value = '1; push_item(it);
    it = rand_item(stm_pkg::CMD_WRITE); it.word_index = 3; push_item(it);
    it = rand_item(stm_pkg::CMD_WRITE); it.word_index = 2; it.word_value = 32'hAAAA5555;
    push_item(it);
    it = rand_item(stm_pkg::CMD_LOAD); it.char_code = 63; it.char_index = 31; push_item(it);
    it = rand_item(stm_pkg::CMD_UNUSED); push_item(it);
    drain();
    random_config(1);
    it = rand_item(stm_pkg::CMD_RENDER); it.scroll_step = 0; push_item(it);
    drain();
    write_reg(stm_pkg::REG_WINDOW_LEFT, 6'd8);
    write_reg(stm_pkg::REG_WINDOW_RIGHT, 6'd3);
    it = rand_item(stm_pkg::CMD_RENDER); push_item(it);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 81 : (ph == 3) ? 37 : 0;
      recv_stall_pct = (ph == 2) ? 81 : (ph == 3) ? 37 : 0;
      random_config((ph == 0) ? 0 : 2);
      if (ph == 0) hold_cycles = 300;
      for (int i = 0; i < 260; i++) begin
        it = rand_item(($urandom_range(9) < 6) ? stm_pkg::CMD_RENDER : $urandom_range(3));
        push_item(it);
        if (i == 130) drain();
      end
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.pending_frames.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: sim.f
hw/rtl/stm_pkg.sv
hw/rtl/stm_front.sv
hw/rtl/stm_back.sv
hw/rtl/scrolling_text_marquee_renderer_unit.sv
dv/scrolling_text_marquee_renderer_unit_tb.sv
